// File: hw/rtl/b64c_pkg.sv
// Shared types, register indexes and character mapping functions of the base64 codec.
`timescale 1ns / 1ps

package b64c_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Register indexes on the configuration port (word address).
    localparam logic [2:0] REG_DECODE_MODE = 3'd0;
    localparam logic [2:0] REG_SYMBOL_62   = 3'd1;
    localparam logic [2:0] REG_SYMBOL_63   = 3'd2;
    localparam logic [2:0] REG_PAD_SYMBOL  = 3'd3;
    localparam logic [2:0] REG_PAD_ENABLE  = 3'd4;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHR = 2'd1;
    localparam logic [1:0] STATUS_BAD_PAD = 2'd2;

    localparam logic [6:0] LOOKUP_PAD = 7'd64;
    localparam logic [6:0] LOOKUP_BAD = 7'd65;

    typedef struct packed {
        logic       decode_mode;
        logic [7:0] symbol_62;
        logic [7:0] symbol_63;
        logic [7:0] pad_symbol;
        logic       pad_enable;
    } cfg_t;

    // Results caused by one input item; bytes[0] is delivered first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            data_valid;
        logic            eos;
        logic [1:0]      status;
    } job_t;

    function automatic logic [7:0] value_to_char(input logic [5:0] v,
                                                 input logic [7:0] s62,
                                                 input logic [7:0] s63);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'd65 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'd71 + {2'b00, v};
        end else if (v < 6'd62) begin
            r = {2'b00, v} - 8'd4;
        end else if (v == 6'd62) begin
            r = s62;
        end else begin
            r = s63;
        end
        return r;
    endfunction

    function automatic logic [6:0] char_to_value(input logic [7:0] c,
                                                 input logic [7:0] s62,
                                                 input logic [7:0] s63,
                                                 input logic [7:0] pad_sym,
                                                 input logic       pad_en);
        logic [7:0] t;
        logic [6:0] r;
        t = 8'd0;
        if (c >= 8'd65 && c <= 8'd90) begin
            t = c - 8'd65;
            r = {1'b0, t[5:0]};
        end else if (c >= 8'd97 && c <= 8'd122) begin
            t = c - 8'd71;
            r = {1'b0, t[5:0]};
        end else if (c >= 8'd48 && c <= 8'd57) begin
            t = c + 8'd4;
            r = {1'b0, t[5:0]};
        end else if (c == s62) begin
            r = 7'd62;
        end else if (c == s63) begin
            r = 7'd63;
        end else if (pad_en && c == pad_sym) begin
            r = LOOKUP_PAD;
        end else begin
            r = LOOKUP_BAD;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/b64c_front.sv
// Front end: accepts items, keeps the group state and builds at most one result job per item.
`timescale 1ns / 1ps

module b64c_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  b64c_pkg::cfg_t cfg,
    input  logic          clear,
    input  logic          accept,
    input  logic          operation,
    input  logic [7:0]    in_byte,
    output logic          push,
    output b64c_pkg::job_t job
);
    import b64c_pkg::*;

    logic [23:0] bit_buffer_reg, bit_buffer_next;
    logic [2:0]  group_count_reg, group_count_next;
    logic [1:0]  pad_count_reg, pad_count_next;
    logic        halted_reg, halted_next;

    logic [23:0] bb;
    logic [23:0] sb;
    logic [2:0]  gcn;
    logic [2:0]  pcn;
    logic [3:0]  total;
    logic [6:0]  v;
    logic [7:0]  pad_chr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_buffer_reg  <= '0;
            group_count_reg <= '0;
            pad_count_reg   <= '0;
            halted_reg      <= 1'b0;
        end else begin
            bit_buffer_reg  <= bit_buffer_next;
            group_count_reg <= group_count_next;
            pad_count_reg   <= pad_count_next;
            halted_reg      <= halted_next;
        end
    end

    always_comb begin
        bit_buffer_next  = bit_buffer_reg;
        group_count_next = group_count_reg;
        pad_count_next   = pad_count_reg;
        halted_next      = halted_reg;
        push             = 1'b0;
        job              = '0;
        job.status       = STATUS_OK;
        bb               = '0;
        sb               = '0;
        gcn              = group_count_reg;
        pcn              = {1'b0, pad_count_reg};
        total            = {1'b0, group_count_reg} + {2'b00, pad_count_reg};
        v                = char_to_value(in_byte, cfg.symbol_62, cfg.symbol_63,
                                         cfg.pad_symbol, cfg.pad_enable);
        pad_chr          = cfg.pad_symbol;

        if (clear) begin
            bit_buffer_next  = '0;
            group_count_next = '0;
            pad_count_next   = '0;
            halted_next      = 1'b0;
        end else if (accept) begin
            if (!cfg.decode_mode) begin
                if (!operation) begin
                    bb  = {bit_buffer_reg[15:0], in_byte};
                    gcn = group_count_reg + 3'd1;
                    if (gcn >= 3'd3) begin
                        push             = 1'b1;
                        job.data_valid   = 1'b1;
                        job.count        = 3'd4;
                        job.bytes[0]     = value_to_char(bb[23:18], cfg.symbol_62, cfg.symbol_63);
                        job.bytes[1]     = value_to_char(bb[17:12], cfg.symbol_62, cfg.symbol_63);
                        job.bytes[2]     = value_to_char(bb[11:6], cfg.symbol_62, cfg.symbol_63);
                        job.bytes[3]     = value_to_char(bb[5:0], cfg.symbol_62, cfg.symbol_63);
                        bit_buffer_next  = '0;
                        group_count_next = '0;
                        pad_count_next   = '0;
                        halted_next      = 1'b0;
                    end else begin
                        bit_buffer_next  = bb;
                        group_count_next = gcn;
                    end
                end else begin
                    push    = 1'b1;
                    job.eos = 1'b1;
                    if (group_count_reg == 3'd1) begin
                        sb             = {bit_buffer_reg[7:0], 16'd0};
                        job.data_valid = 1'b1;
                        job.count      = cfg.pad_enable ? 3'd4 : 3'd2;
                        job.bytes[0]   = value_to_char(sb[23:18], cfg.symbol_62, cfg.symbol_63);
                        job.bytes[1]   = value_to_char(sb[17:12], cfg.symbol_62, cfg.symbol_63);
                        job.bytes[2]   = pad_chr;
                        job.bytes[3]   = pad_chr;
                    end else if (group_count_reg == 3'd2) begin
                        sb             = {bit_buffer_reg[15:0], 8'd0};
                        job.data_valid = 1'b1;
                        job.count      = cfg.pad_enable ? 3'd4 : 3'd3;
                        job.bytes[0]   = value_to_char(sb[23:18], cfg.symbol_62, cfg.symbol_63);
                        job.bytes[1]   = value_to_char(sb[17:12], cfg.symbol_62, cfg.symbol_63);
                        job.bytes[2]   = value_to_char(sb[11:6], cfg.symbol_62, cfg.symbol_63);
                        job.bytes[3]   = pad_chr;
                    end else begin
                        job.count = 3'd1;
                    end
                    bit_buffer_next  = '0;
                    group_count_next = '0;
                    pad_count_next   = '0;
                    halted_next      = 1'b0;
                end
            end else begin
                if (operation) begin
                    push    = 1'b1;
                    job.eos = 1'b1;
                    case (total)
                        4'd1:    sb = {bit_buffer_reg[5:0], 18'd0};
                        4'd2:    sb = {bit_buffer_reg[11:0], 12'd0};
                        default: sb = {bit_buffer_reg[17:0], 6'd0};
                    endcase
                    job.bytes[0] = sb[23:16];
                    job.bytes[1] = sb[15:8];
                    if (!halted_reg && group_count_reg > 3'd1 && total < 4'd4) begin
                        job.data_valid = 1'b1;
                        job.count      = group_count_reg - 3'd1;
                    end else begin
                        job.bytes = '0;
                        job.count = 3'd1;
                    end
                    bit_buffer_next  = '0;
                    group_count_next = '0;
                    pad_count_next   = '0;
                    halted_next      = 1'b0;
                end else if (!halted_reg) begin
                    if (v == LOOKUP_BAD) begin
                        halted_next = 1'b1;
                        push        = 1'b1;
                        job.count   = 3'd1;
                        job.status  = STATUS_BAD_CHR;
                    end else begin
                        if (v == LOOKUP_PAD) begin
                            pcn = {1'b0, pad_count_reg} + 3'd1;
                        end else begin
                            gcn = group_count_reg + 3'd1;
                        end
                        bb    = {bit_buffer_reg[17:0], (v == LOOKUP_PAD) ? 6'd0 : v[5:0]};
                        total = {1'b0, gcn} + {1'b0, pcn};
                        if (pcn > 3'd2) begin
                            // A third pad within one group is an error.
                            halted_next = 1'b1;
                            push        = 1'b1;
                            job.count   = 3'd1;
                            job.status  = STATUS_BAD_PAD;
                        end else if (total >= 4'd4) begin
                            push             = 1'b1;
                            job.data_valid   = 1'b1;
                            job.count        = gcn - 3'd1;
                            job.bytes[0]     = bb[23:16];
                            job.bytes[1]     = bb[15:8];
                            job.bytes[2]     = bb[7:0];
                            bit_buffer_next  = '0;
                            group_count_next = '0;
                            pad_count_next   = '0;
                        end else begin
                            bit_buffer_next  = bb;
                            group_count_next = gcn;
                            pad_count_next   = pcn[1:0];
                        end
                    end
                end
            end
        end
    end

endmodule

// File: hw/rtl/b64c_queue.sv
// Short job queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module b64c_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  b64c_pkg::job_t push_job,
    input  logic           pop,
    output b64c_pkg::job_t head_job,
    output logic           not_empty,
    output logic           full
);
    import b64c_pkg::*;

    job_t               entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    fill_reg, fill_next;

    assign not_empty = (fill_reg != '0);
    assign full      = (fill_reg == (QPTR_W+1)'(QDEPTH));
    assign head_job  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hw/rtl/b64c_back.sv
// Output sequencer: takes one job at a time and delivers its results one per cycle while m_tready is high.
`timescale 1ns / 1ps

module b64c_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  b64c_pkg::job_t head_job,
    input  logic           not_empty,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast,
    output logic [3:0]     m_tuser
);
    import b64c_pkg::*;

    job_t       job_reg;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       last;

    assign last     = ({1'b0, idx_reg} + 3'd1 == job_reg.count);
    assign pop      = not_empty && (!busy_reg || (m_tready && last));
    assign m_tvalid = busy_reg;
    assign m_tdata  = job_reg.data_valid ? job_reg.bytes[idx_reg] : 8'd0;
    assign m_tlast  = last;
    assign m_tuser  = {job_reg.status, job_reg.eos && last, job_reg.data_valid};

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (busy_reg && m_tready) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= head_job;
        end
    end

endmodule

// File: hw/rtl/base64_stream_codec.sv
// Top level of the base64 codec: configuration registers and the front, queue and back parts.
// The first result of an item is written into the job queue and then loaded into the output
// sequencer's job register before it is presented on m_tdata.
// One item per cycle is accepted while the two-entry job queue has room; results leave at
// one per cycle while m_tready is high.
// Reset (aresetn low, synchronous) clears the group state, the queue and the output
// sequencer, and sets the registers to standard base64 with padding in encode mode.
`timescale 1ns / 1ps

module base64_stream_codec (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [3:0]  m_tuser,   // [0] out_valid, [1] stream_end, [3:2] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import b64c_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic       clear;
    logic       accept;
    logic       push;
    logic       pop;
    logic       not_empty;
    logic       full;
    job_t       push_job;
    job_t       head_job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    // Writing the mode register starts a fresh message.
    assign clear   = wr_en && (reg_idx == REG_DECODE_MODE);

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_DECODE_MODE: cfg_next.decode_mode = pwdata[0];
                REG_SYMBOL_62:   cfg_next.symbol_62   = pwdata[7:0];
                REG_SYMBOL_63:   cfg_next.symbol_63   = pwdata[7:0];
                REG_PAD_SYMBOL:  cfg_next.pad_symbol  = pwdata[7:0];
                REG_PAD_ENABLE:  cfg_next.pad_enable  = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.decode_mode <= 1'b0;
            cfg_reg.symbol_62   <= 8'd43;
            cfg_reg.symbol_63   <= 8'd47;
            cfg_reg.pad_symbol  <= 8'd61;
            cfg_reg.pad_enable  <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DECODE_MODE: prdata = {31'd0, cfg_reg.decode_mode};
            REG_SYMBOL_62:   prdata = {24'd0, cfg_reg.symbol_62};
            REG_SYMBOL_63:   prdata = {24'd0, cfg_reg.symbol_63};
            REG_PAD_SYMBOL:  prdata = {24'd0, cfg_reg.pad_symbol};
            REG_PAD_ENABLE:  prdata = {31'd0, cfg_reg.pad_enable};
            default:         prdata = 32'd0;
        endcase
    end

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    b64c_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .clear     (clear),
        .accept    (accept),
        .operation (s_tuser[0]),
        .in_byte   (s_tdata),
        .push      (push),
        .job       (push_job)
    );

    b64c_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head_job  (head_job),
        .not_empty (not_empty),
        .full      (full)
    );

    b64c_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_job  (head_job),
        .not_empty (not_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
